// ----- design/bsc_pkg.sv -----
// Package for the barometer compensation block: operation struct, configuration indices and constants.
// Used by the arithmetic units and the top level sequencer.
`default_nettype none
package bsc_pkg;
  localparam logic [31:0] K_B6_OFFSET = 32'd4000;
  localparam logic [31:0] K_C3038     = 32'd3038;
  localparam logic [31:0] K_CM7357    = 32'hFFFF_E343;
  localparam logic [31:0] K_C3791     = 32'd3791;
  localparam logic [31:0] K_C50000    = 32'd50000;
  localparam logic [31:0] K_C32768    = 32'd32768;
  localparam logic [31:0] K_SIGN      = 32'h8000_0000;
  localparam int unsigned NUM_CFG = 6;
  localparam logic [2:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [2:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [2:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [2:0] CFG_B1_B2   = 3'd3;
  localparam logic [2:0] CFG_MC_MD   = 3'd4;
  localparam logic [2:0] CFG_OSS     = 3'd5;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } bsc_op_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    asr32 = 32'($signed(v) >>> s);
  endfunction
endpackage
`default_nettype wire

// ----- design/bsc_mul.sv -----
// Bit-serial 32x32 multiplier, low 32 bits of the product, one bit per cycle.
// Depends on bsc_pkg.
`default_nettype none
module bsc_mul import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire bsc_op_t     op,
  output logic             done,
  output logic [31:0]      prod
);
  logic [31:0] acc_r, acc_nxt, mcand_r, mcand_nxt, mplier_r, mplier_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (op.start) begin
      acc_nxt = '0;
      mcand_nxt = op.a;
      mplier_nxt = op.b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = {mcand_r[30:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[31:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ----- design/bsc_div.sv -----
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on bsc_pkg.
`default_nettype none
module bsc_div import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire bsc_op_t     op,
  output logic             done,
  output logic [31:0]      quot
);
  logic [31:0] q_r, q_nxt, d_r, d_nxt;
  logic [32:0] rem_r, rem_nxt, trial;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt = q_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};
    if (op.start) begin
      q_nxt = op.a;
      d_nxt = op.b;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

// ----- design/baro_sensor_compensation.sv -----
// Barometer compensation top level: calibration registers, sequencer, serial units.
// One reading at a time: the result register is loaded once it is free, and the next input
// is taken in the cycle after it is loaded. Synchronous reset clears the calibration
// registers, the sequencer state, out_valid and temp_term. Depends on bsc_pkg, bsc_mul and bsc_div.
`default_nettype none
module baro_sensor_compensation import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [23:0] in_raw_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic signed [31:0] out_value,
  output logic             out_div_error,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_T1 = 5'd1,  S_T2 = 5'd2,  S_T3 = 5'd3,
                         S_P1 = 5'd4,  S_P2 = 5'd5,  S_P3 = 5'd6,  S_P4 = 5'd7,
                         S_P5 = 5'd8,  S_P6 = 5'd9,  S_P7 = 5'd10, S_P8 = 5'd11,
                         S_P9 = 5'd12, S_P10 = 5'd13, S_P11 = 5'd14, S_P12 = 5'd15,
                         S_OUT = 5'd16;

  logic [31:0] cal_r [5];
  logic [1:0]  oss_r;
  logic [31:0] temp_term_r, temp_term_nxt;
  logic [4:0]  st_r, st_nxt;
  logic        func_r, func_nxt;
  logic [23:0] raw_r, raw_nxt;
  logic [31:0] t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  logic        neg_r, neg_nxt;
  logic        ov_r, ov_nxt, ok_r, ok_nxt, oe_r, oe_nxt, ok2_r, ok2_nxt;
  logic [31:0] ovl_r, ovl_nxt;
  bsc_op_t     mop, dop;
  logic        mdone, ddone;
  logic [31:0] prod, quot;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{cal_r[0][31]}}, cal_r[0][31:16]};
  assign ac2 = {{16{cal_r[0][15]}}, cal_r[0][15:0]};
  assign ac3 = {{16{cal_r[1][31]}}, cal_r[1][31:16]};
  assign ac4 = {16'd0, cal_r[1][15:0]};
  assign ac5 = {16'd0, cal_r[2][31:16]};
  assign ac6 = {16'd0, cal_r[2][15:0]};
  assign b1  = {{16{cal_r[3][31]}}, cal_r[3][31:16]};
  assign b2  = {{16{cal_r[3][15]}}, cal_r[3][15:0]};
  assign mc  = {{16{cal_r[4][31]}}, cal_r[4][31:16]};
  assign md  = {{16{cal_r[4][15]}}, cal_r[4][15:0]};

  bsc_mul u_mul (.clk(clk), .rst_n(rst_n), .op(mop), .done(mdone), .prod(prod));
  bsc_div u_div (.clk(clk), .rst_n(rst_n), .op(dop), .done(ddone), .quot(quot));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        cal_r[i] <= '0;
      end
      oss_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AC1_AC2: cal_r[0] <= cfg_data;
        CFG_AC3_AC4: cal_r[1] <= cfg_data;
        CFG_AC5_AC6: cal_r[2] <= cfg_data;
        CFG_B1_B2:   cal_r[3] <= cfg_data;
        CFG_MC_MD:   cal_r[4] <= cfg_data;
        CFG_OSS:     oss_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] nabs, dabs, b3, x3v, sq;
  always_comb begin
    st_nxt = st_r;
    func_nxt = func_r;
    raw_nxt = raw_r;
    t0_nxt = t0_r; t1_nxt = t1_r; t2_nxt = t2_r; t3_nxt = t3_r;
    neg_nxt = neg_r;
    temp_term_nxt = temp_term_r;
    ov_nxt = ov_r; ok_nxt = ok_r; oe_nxt = oe_r; ovl_nxt = ovl_r; ok2_nxt = ok2_r;
    mop = '0;
    dop = '0;
    nabs = '0; dabs = '0; b3 = '0; x3v = '0; sq = '0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          raw_nxt = in_raw_value;
          if (in_func) begin
            t0_nxt = temp_term_r - K_B6_OFFSET;
            mop = '{start: 1'b1, a: temp_term_r - K_B6_OFFSET,
                    b: temp_term_r - K_B6_OFFSET};
            st_nxt = S_P1;
          end else begin
            mop = '{start: 1'b1, a: {16'd0, in_raw_value[15:0]} - ac6, b: ac5};
            st_nxt = S_T1;
          end
        end
      end
      S_T1: if (mdone) begin
        t1_nxt = asr32(prod, 5'd15);
        if (asr32(prod, 5'd15) + md == 32'd0) begin
          ok2_nxt = 1'b1;
          st_nxt = S_OUT;
        end else begin
          dabs = asr32(prod, 5'd15) + md;
          neg_nxt = mc[31] ^ dabs[31];
          nabs = mc << 11;
          dop = '{start: 1'b1, a: nabs[31] ? 32'd0 - nabs : nabs,
                  b: dabs[31] ? 32'd0 - dabs : dabs};
          ok2_nxt = 1'b0;
          st_nxt = S_T2;
        end
      end
      S_T2: if (ddone) begin
        temp_term_nxt = t1_r + (neg_r ? 32'd0 - quot : quot);
        t2_nxt = asr32(t1_r + (neg_r ? 32'd0 - quot : quot) + 32'd8, 5'd4);
        st_nxt = S_OUT;
      end
      // Pressure: t0 = B6.
      S_P1: if (mdone) begin
        t1_nxt = asr32(prod, 5'd12);   // sq
        mop = '{start: 1'b1, a: b2, b: asr32(prod, 5'd12)};
        st_nxt = S_P2;
      end
      S_P2: if (mdone) begin
        t2_nxt = asr32(prod, 5'd11);   // x1
        mop = '{start: 1'b1, a: ac2, b: t0_r};
        st_nxt = S_P3;
      end
      S_P3: if (mdone) begin
        x3v = t2_r + asr32(prod, 5'd11);
        nabs = ((ac1 * 32'd4 + x3v) << oss_r) + 32'd2;
        // Signed divide by four, truncating toward zero.
        b3 = nabs[31] ? 32'd0 - ((32'd0 - nabs) >> 2) : nabs >> 2;
        t2_nxt = b3;
        mop = '{start: 1'b1, a: ac3, b: t0_r};
        st_nxt = S_P4;
      end
      S_P4: if (mdone) begin
        t3_nxt = asr32(prod, 5'd13);
        mop = '{start: 1'b1, a: b1, b: t1_r};
        st_nxt = S_P5;
      end
      S_P5: if (mdone) begin
        x3v = asr32(t3_r + asr32(prod, 5'd16) + 32'd2, 5'd2);
        mop = '{start: 1'b1, a: ac4, b: x3v + K_C32768};
        st_nxt = S_P6;
      end
      S_P6: if (mdone) begin
        t3_nxt = prod >> 15;          // B4
        mop = '{start: 1'b1, a: ({8'd0, raw_r} >> (4'd8 - {2'd0, oss_r})) - t2_r,
                b: K_C50000 >> oss_r};
        st_nxt = S_P7;
      end
      S_P7: if (mdone) begin
        if (t3_r == 32'd0) begin
          ok2_nxt = 1'b1;
          st_nxt = S_OUT;
        end else begin
          ok2_nxt = 1'b0;
          neg_nxt = prod[31];
          dop = '{start: 1'b1, a: prod[31] ? prod : prod << 1, b: t3_r};
          st_nxt = S_P8;
        end
      end
      S_P8: if (ddone) begin
        t0_nxt = neg_r ? quot << 1 : quot;  // p
        sq = asr32(neg_r ? quot << 1 : quot, 5'd8);
        mop = '{start: 1'b1, a: sq, b: sq};
        st_nxt = S_P9;
      end
      S_P9: if (mdone) begin
        mop = '{start: 1'b1, a: prod, b: K_C3038};
        st_nxt = S_P10;
      end
      S_P10: if (mdone) begin
        t1_nxt = asr32(prod, 5'd16);
        mop = '{start: 1'b1, a: K_CM7357, b: t0_r};
        st_nxt = S_P11;
      end
      S_P11: if (mdone) begin
        t2_nxt = t0_r + asr32(t1_r + asr32(prod, 5'd16) + K_C3791, 5'd4);
        st_nxt = S_OUT;
      end
      S_OUT: if (!ov_r) begin
        ov_nxt = 1'b1;
        ok_nxt = func_r;
        oe_nxt = ok2_r;
        ovl_nxt = ok2_r ? 32'd0 : t2_r;
        ok2_nxt = 1'b0;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      temp_term_r <= '0;
      ok2_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      temp_term_r <= temp_term_nxt;
      ok2_r <= ok2_nxt;
    end
    func_r <= func_nxt;
    raw_r <= raw_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; t2_r <= t2_nxt; t3_r <= t3_nxt;
    neg_r <= neg_nxt;
    ok_r <= ok_nxt; oe_r <= oe_nxt; ovl_r <= ovl_nxt;
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_value = $signed(ovl_r);
  assign out_div_error = oe_r;
endmodule
`default_nettype wire
